// ----- hw/rtl/ssbt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssbt_pkg;

    // width of the duration countdown and the stored intervals
    localparam int TIMER_BITS = 24;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_SHOW   = 3'd2;
    localparam logic [2:0] OP_BLINK  = 3'd3;
    localparam logic [2:0] OP_SELECT = 3'd4;
    localparam logic [2:0] OP_TOGGLE = 3'd5;

    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [6:0]            t_segments;

    // segments a..g in bits 0..6, codes above nine blank
    function automatic t_segments seg_decode(input logic [3:0] digit);
        t_segments seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/seven_segment_blink_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Seven-segment blink timer: every accepted item (a one-millisecond tick or a
// command) updates the display state in the cycle it is accepted and yields
// exactly one result, registered and valid on the next cycle. One item can be
// accepted every clock cycle; the single result register sets that figure, and
// the input is ready whenever that register is empty or being drained. Segment
// and common line levels follow the display polarity setting in force when the
// item is accepted; write it only while no item is in flight.
module seven_segment_blink_timer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [3:0]  i_digit,
    input  wire logic [23:0] i_on_time,
    input  wire logic [23:0] i_off_time,
    input  wire logic [7:0]  i_blink_count,
    input  wire logic        i_select_level,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [6:0]       o_segment_lines,
    output logic             o_common_line,
    output logic             o_lit,
    output logic             o_busy_res
);

    logic                r_anode_mode;
    ssbt_pkg::t_segments r_pattern,  n_pattern;
    logic                r_enabled,  n_enabled;
    logic                r_show,     n_show;
    logic [7:0]          r_blinks,   n_blinks;
    ssbt_pkg::t_timer    r_on_ivl,   n_on_ivl;
    ssbt_pkg::t_timer    r_off_ivl,  n_off_ivl;
    ssbt_pkg::t_timer    r_count,    n_count;
    logic                r_busy,     n_busy;

    logic                r_out_valid;
    logic [6:0]          r_seg_out;
    logic                r_com_out;
    logic                r_lit_out;
    logic                r_busy_out;

    logic                in_accept;
    ssbt_pkg::t_timer    on_time;
    ssbt_pkg::t_timer    off_time;
    ssbt_pkg::t_timer    tick_count;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign on_time    = i_on_time[ssbt_pkg::TIMER_BITS-1:0];
    assign off_time   = i_off_time[ssbt_pkg::TIMER_BITS-1:0];
    // saturating decrement
    assign tick_count = (r_count != '0) ? r_count - ssbt_pkg::t_timer'(1) : r_count;

    always_comb begin
        n_pattern = r_pattern;
        n_enabled = r_enabled;
        n_show    = r_show;
        n_blinks  = r_blinks;
        n_on_ivl  = r_on_ivl;
        n_off_ivl = r_off_ivl;
        n_count   = r_count;
        n_busy    = r_busy;
        unique case (i_opcode)
            ssbt_pkg::OP_TICK: begin
                n_count = tick_count;
                if (tick_count == '0) begin
                    if (r_show) begin
                        n_enabled = 1'b0;
                        n_show    = 1'b0;
                        n_busy    = 1'b0;
                    end else if (r_blinks != '0) begin
                        n_enabled = !r_enabled;
                        if (r_enabled) begin
                            // turning off ends one blink
                            n_count  = r_off_ivl;
                            n_blinks = r_blinks - 8'd1;
                        end else begin
                            n_count = r_on_ivl;
                        end
                        n_busy = (n_blinks != '0);
                    end
                end
            end
            ssbt_pkg::OP_SET: begin
                n_pattern = ssbt_pkg::seg_decode(i_digit);
            end
            ssbt_pkg::OP_SHOW: begin
                n_blinks  = '0;
                n_show    = 1'b1;
                n_enabled = 1'b1;
                n_count   = on_time;
                n_busy    = 1'b1;
            end
            ssbt_pkg::OP_BLINK: begin
                n_show    = 1'b0;
                n_blinks  = i_blink_count;
                n_on_ivl  = on_time;
                n_off_ivl = off_time;
                n_enabled = 1'b1;
                n_count   = on_time;
                n_busy    = (i_blink_count != '0);
            end
            ssbt_pkg::OP_SELECT: begin
                n_enabled = i_select_level;
            end
            ssbt_pkg::OP_TOGGLE: begin
                n_enabled = !r_enabled;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anode_mode <= 1'b0;
            r_pattern    <= '0;
            r_enabled    <= 1'b0;
            r_show       <= 1'b0;
            r_blinks     <= '0;
            r_on_ivl     <= '0;
            r_off_ivl    <= '0;
            r_count      <= '0;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_anode_mode <= i_cfg_data;
            end
            if (in_accept) begin
                r_pattern   <= n_pattern;
                r_enabled   <= n_enabled;
                r_show      <= n_show;
                r_blinks    <= n_blinks;
                r_on_ivl    <= n_on_ivl;
                r_off_ivl   <= n_off_ivl;
                r_count     <= n_count;
                r_busy      <= n_busy;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, polarity applied on the way in
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_seg_out  <= r_anode_mode ? ~n_pattern : n_pattern;
            r_com_out  <= r_anode_mode ? n_enabled : !n_enabled;
            r_lit_out  <= n_enabled;
            r_busy_out <= n_busy;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_segment_lines = r_seg_out;
    assign o_common_line   = r_com_out;
    assign o_lit           = r_lit_out;
    assign o_busy_res      = r_busy_out;

endmodule

`default_nettype wire

// ----- hw/rtl/ssbt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssbt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [2:0]  i_opcode,
    input wire logic [7:0]  i_blink_count,
    input wire logic        i_select_level,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [6:0]  o_segment_lines,
    input wire logic        o_common_line,
    input wire logic        o_lit,
    input wire logic        o_busy_res
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_segment_lines) && $stable(o_common_line)
            && $stable(o_lit) && $stable(o_busy_res))
        else $error("result changed while stalled");

    // every accepted item yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("no result after accepted item");

    // show lights the display and marks a task pending
    a_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_opcode == ssbt_pkg::OP_SHOW |=> o_lit && o_busy_res)
        else $error("show result wrong");

    // blink with zero count stays lit with nothing pending
    a_blink_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_opcode == ssbt_pkg::OP_BLINK && i_blink_count == '0
            |=> o_lit && !o_busy_res)
        else $error("zero-count blink result wrong");

    // select sets the display level directly
    a_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_opcode == ssbt_pkg::OP_SELECT |=> o_lit == $past(i_select_level))
        else $error("select result wrong");

endmodule

bind seven_segment_blink_timer ssbt_checker u_ssbt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_opcode        (i_opcode),
    .i_blink_count   (i_blink_count),
    .i_select_level  (i_select_level),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_segment_lines (o_segment_lines),
    .o_common_line   (o_common_line),
    .o_lit           (o_lit),
    .o_busy_res      (o_busy_res)
);

`default_nettype wire

// ----- bench/tb_seven_segment_blink_timer.sv -----
`timescale 1ns / 1ps

module tb_seven_segment_blink_timer;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int END_SETTLE  = 4;
    localparam int LONG_HOLD   = 300;

    // glyphs for codes 15 down to 0, seven bits each
    localparam logic [111:0] GLYPHS = {
        {6{7'h00}}, 7'h6F, 7'h7F, 7'h07, 7'h7D,
        7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    typedef struct packed {
        logic [2:0]       op;
        logic [3:0]       digit;
        ssbt_pkg::t_timer on_t;
        ssbt_pkg::t_timer off_t;
        logic [7:0]       count;
        logic             level;
    } t_disp_cmd;

    typedef struct packed {
        ssbt_pkg::t_segments segs;
        logic                common;
        logic                lit;
        logic                busy;
    } t_disp_res;

    typedef enum int {SINK_OPEN, SINK_BUSY, SINK_CHOKED, SINK_PERIODIC} t_sink_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_opcode = ssbt_pkg::OP_TICK;
    logic [3:0]  i_digit = '0;
    logic [23:0] i_on_time = '0;
    logic [23:0] i_off_time = '0;
    logic [7:0]  i_blink_count = '0;
    logic        i_select_level = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [6:0]  o_segment_lines;
    logic        o_common_line;
    logic        o_lit;
    logic        o_busy_res;

    // display model state
    logic                anode_mode = 1'b0;
    ssbt_pkg::t_segments glyph_now = '0;
    logic                disp_on = 1'b0;
    logic                show_pend = 1'b0;
    logic [7:0]          blinks_rem = '0;
    ssbt_pkg::t_timer    on_iv = '0;
    ssbt_pkg::t_timer    off_iv = '0;
    ssbt_pkg::t_timer    time_left = '0;
    logic                task_busy = 1'b0;

    t_disp_res pending_displays[$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    int        hold_off_left = 0;
    int        cycle_count = 0;

    seven_segment_blink_timer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_digit         (i_digit),
        .i_on_time       (i_on_time),
        .i_off_time      (i_off_time),
        .i_blink_count   (i_blink_count),
        .i_select_level  (i_select_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_segment_lines (o_segment_lines),
        .o_common_line   (o_common_line),
        .o_lit           (o_lit),
        .o_busy_res      (o_busy_res)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_disp_res predict_display(input t_disp_cmd c);
        t_disp_res r;
        case (c.op)
            ssbt_pkg::OP_TICK: begin
                if (time_left != '0) begin
                    time_left = time_left - ssbt_pkg::t_timer'(1);
                end
                if (time_left == '0) begin
                    if (show_pend) begin
                        disp_on   = 1'b0;
                        show_pend = 1'b0;
                        task_busy = 1'b0;
                    end else if (blinks_rem != '0) begin
                        disp_on = !disp_on;
                        // a blink is counted when it goes dark
                        if (!disp_on) begin
                            time_left  = off_iv;
                            blinks_rem = blinks_rem - 8'd1;
                        end else begin
                            time_left = on_iv;
                        end
                        task_busy = (blinks_rem != '0);
                    end
                end
            end
            ssbt_pkg::OP_SET: begin
                glyph_now = GLYPHS[c.digit * 7 +: 7];
            end
            ssbt_pkg::OP_SHOW: begin
                blinks_rem = '0;
                show_pend  = 1'b1;
                disp_on    = 1'b1;
                time_left  = c.on_t;
                task_busy  = 1'b1;
            end
            ssbt_pkg::OP_BLINK: begin
                show_pend  = 1'b0;
                blinks_rem = c.count;
                on_iv      = c.on_t;
                off_iv     = c.off_t;
                disp_on    = 1'b1;
                time_left  = c.on_t;
                task_busy  = (c.count != '0);
            end
            ssbt_pkg::OP_SELECT: begin
                disp_on = c.level;
            end
            ssbt_pkg::OP_TOGGLE: begin
                disp_on = !disp_on;
            end
            default: begin
            end
        endcase
        r.segs   = anode_mode ? ~glyph_now : glyph_now;
        r.common = anode_mode ? disp_on : !disp_on;
        r.lit    = disp_on;
        r.busy   = task_busy;
        return r;
    endfunction

    function automatic t_disp_cmd mk_cmd(input logic [2:0] op, input logic [3:0] digit,
                                         input ssbt_pkg::t_timer on_t,
                                         input ssbt_pkg::t_timer off_t,
                                         input logic [7:0] count, input logic level);
        t_disp_cmd c;
        c.op    = op;
        c.digit = digit;
        c.on_t  = on_t;
        c.off_t = off_t;
        c.count = count;
        c.level = level;
        return c;
    endfunction

    function automatic t_disp_cmd rand_cmd();
        t_disp_cmd c;
        c.op    = 3'($urandom_range(0, 7));
        c.digit = 4'($urandom);
        c.on_t  = ssbt_pkg::t_timer'($urandom);
        c.off_t = ssbt_pkg::t_timer'($urandom);
        c.count = 8'($urandom);
        c.level = 1'($urandom);
        return c;
    endfunction

    task automatic compare_field(input string name, input logic [6:0] want,
                                 input logic [6:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_display();
        t_disp_res want;
        if (pending_displays.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual seg %h com %b lit %b busy %b",
                     $time, o_segment_lines, o_common_line, o_lit, o_busy_res);
            fail_count++;
        end else begin
            want = pending_displays.pop_front();
            compare_field("segment_lines", want.segs, o_segment_lines);
            compare_field("common_line", 7'(want.common), 7'(o_common_line));
            compare_field("lit", 7'(want.lit), 7'(o_lit));
            compare_field("busy_res", 7'(want.busy), 7'(o_busy_res));
        end
    endtask

    // result side: checks each handshake and stalls on its own pattern
    initial begin : result_sink
        t_sink_mode mode;
        int         phase_left;
        int         phase_pos;
        mode       = SINK_OPEN;
        phase_left = 0;
        phase_pos  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_display();
            end
            if (phase_left == 0) begin
                mode       = t_sink_mode'($urandom_range(0, 3));
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            phase_pos++;
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_OPEN:   i_out_ready <= 1'b1;
                    SINK_BUSY:   i_out_ready <= ($urandom_range(0, 3) != 0);
                    SINK_CHOKED: i_out_ready <= ($urandom_range(0, 9) < 3);
                    default:     i_out_ready <= (phase_pos % 3 == 0);
                endcase
            end
        end
    end

    task automatic send_item(input t_disp_cmd c);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(40, 120);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= c.op;
        i_digit        <= c.digit;
        i_on_time      <= c.on_t;
        i_off_time     <= c.off_t;
        i_blink_count  <= c.count;
        i_select_level <= c.level;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_displays.push_back(predict_display(c));
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_displays.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_polarity(input logic anode);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= anode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        anode_mode = anode;
    endtask

    // ticks with an occasional set, select or toggle mixed in
    task automatic run_ticks(input int n);
        t_disp_cmd c;
        for (int i = 0; i < n; i++) begin
            c    = rand_cmd();
            c.op = ssbt_pkg::OP_TICK;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                    0:       c.op = ssbt_pkg::OP_SET;
                    1:       c.op = ssbt_pkg::OP_SELECT;
                    default: c.op = ssbt_pkg::OP_TOGGLE;
                endcase
            end
            send_item(c);
        end
    endtask

    task automatic test_directed();
        send_item(mk_cmd(ssbt_pkg::OP_TICK, 4'd0, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_SET, 4'd0, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_SET, 4'd8, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_SET, 4'd10, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_SET, 4'd15, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_SET, 4'd9, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_SELECT, 4'd0, '0, '0, 8'd0, 1'b1));
        send_item(mk_cmd(ssbt_pkg::OP_SELECT, 4'd0, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_TOGGLE, 4'd0, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_TOGGLE, 4'd0, '0, '0, 8'd0, 1'b0));
        // show expires on the second tick
        send_item(mk_cmd(ssbt_pkg::OP_SHOW, 4'd0, 24'd2, '0, 8'd0, 1'b0));
        run_ticks(2);
        // zero-length show goes dark on the first tick
        send_item(mk_cmd(ssbt_pkg::OP_SHOW, 4'd0, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_TICK, 4'd0, '0, '0, 8'd0, 1'b0));
        // two blinks with no off interval
        send_item(mk_cmd(ssbt_pkg::OP_BLINK, 4'd0, 24'd1, '0, 8'd2, 1'b0));
        for (int i = 0; i < 4; i++) begin
            send_item(mk_cmd(ssbt_pkg::OP_TICK, 4'd0, '0, '0, 8'd0, 1'b0));
        end
        // blink with zero count stays lit and not busy
        send_item(mk_cmd(ssbt_pkg::OP_BLINK, 4'd0, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_TICK, 4'd0, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(OP_SPARE6, 4'hF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b1));
        send_item(mk_cmd(OP_SPARE7, 4'hF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b1));
        send_item(mk_cmd(ssbt_pkg::OP_BLINK, 4'hF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b1));
        send_item(mk_cmd(ssbt_pkg::OP_TICK, 4'd0, '0, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_SHOW, 4'd0, 24'hFFFFFF, '0, 8'd0, 1'b0));
        send_item(mk_cmd(ssbt_pkg::OP_TICK, 4'd0, '0, '0, 8'd0, 1'b0));
    endtask

    // mostly blink runs with enough ticks to play out and show runs with a random number of ticks, plus noise
    task automatic test_random_sequences(input int n_items);
        t_disp_cmd c;
        int        target;
        int        kind;
        int        span;
        target = items_sent + n_items;
        while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            c    = rand_cmd();
            if (kind < 40) begin
                c.op    = ssbt_pkg::OP_BLINK;
                c.on_t  = ssbt_pkg::t_timer'($urandom_range(0, 4));
                c.off_t = ssbt_pkg::t_timer'($urandom_range(0, 4));
                c.count = 8'($urandom_range(0, 5));
                send_item(c);
                span = int'(c.count) * (int'(c.on_t) + int'(c.off_t) + 2);
                run_ticks(span + $urandom_range(0, 4));
            end else if (kind < 60) begin
                c.op   = ssbt_pkg::OP_SHOW;
                c.on_t = ssbt_pkg::t_timer'($urandom_range(0, 6));
                send_item(c);
                run_ticks($urandom_range(0, 8));
            end else if (kind < 72) begin
                c.op = ssbt_pkg::OP_SET;
                send_item(c);
            end else if (kind < 84) begin
                c.op = ($urandom_range(0, 1) == 0) ? ssbt_pkg::OP_SELECT : ssbt_pkg::OP_TOGGLE;
                send_item(c);
            end else begin
                send_item(c);
            end
        end
    endtask

    // sink holds off while items keep coming, so the input must stall
    task automatic test_backpressure();
        hold_off_left = LONG_HOLD;
        test_random_sequences(60);
        drain();
    endtask

    initial begin : main_seq
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain();
        write_polarity(1'b1);
        test_random_sequences(420);
        drain();
        test_backpressure();
        write_polarity(1'b0);
        test_random_sequences(420);
        drain();
        write_polarity(1'b1);
        test_random_sequences(400);
        drain();
        write_polarity(1'b0);
        test_random_sequences(350);
        drain();
        repeat (END_SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ssbt_pkg.sv
hw/rtl/seven_segment_blink_timer.sv
hw/rtl/ssbt_checker.sv
bench/tb_seven_segment_blink_timer.sv
